[rtl/core/ltfp_pkg.sv]
// Shared constants and codes for the length-prefixed text frame parser.
// Holds the framing characters, the result event codes and the element kinds.
// No dependencies.
package ltfp_pkg;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      EV_HEADER  = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_ELEMENT = 3'd2,
      EV_COMMAND = 3'd3,
      EV_ERROR   = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_NULL  = 2'd1,
      KIND_BULK  = 2'd2,
      KIND_ARRAY = 2'd3
   } kind_type;

endpackage

[rtl/core/ltfp_accum.sv]
// Decimal header accumulator: classifies a byte as a digit and forms value*10+digit,
// saturating at the all-ones value of the length width.
// Depends on ltfp_pkg for the digit characters.
module ltfp_accum
   import ltfp_pkg::*;
#(
   parameter int LENGTH_BITS = 31
) (
   input  logic [LENGTH_BITS-1:0] value,
   input  logic [7:0]             byte_in,
   output logic                   is_digit,
   output logic [LENGTH_BITS-1:0] value_next
);

   logic [3:0]             digit;
   logic [LENGTH_BITS+3:0] times_ten;
   logic [LENGTH_BITS+3:0] sum;

   assign is_digit  = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
   assign digit     = byte_in[3:0];
   // x10 as x8 + x2
   assign times_ten = {1'b0, value, 3'b000} + {3'b000, value, 1'b0};
   assign sum       = times_ten + {{LENGTH_BITS{1'b0}}, digit};
   // any bit above the length width means the value went past the limit
   assign value_next = (sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
                       {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];

endmodule

[rtl/core/length_prefixed_text_frame_parser.sv]
// Length-prefixed text frame parser: one stream byte in, one result transfer out.
// Latency: a result is valid in the cycle after its byte transfer (one register stage).
// Throughput: one byte per cycle while rsp_tready holds; the result register refills while taken.
// Reset (synchronous, active high) returns the parser to a header line start with all
// counters cleared, clears the sticky error and empties the result register.
// Depends on ltfp_pkg and ltfp_accum.
module length_prefixed_text_frame_parser
   import ltfp_pkg::*;
#(
   parameter int LENGTH_BITS      = 31,
   parameter int COUNT_BITS       = 16,
   parameter int MAX_HEADER_CHARS = 31
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // from bit 0 up: payload_byte, element_length, children_pending,
   // total_elements, top_level_elements, zero fill to whole bytes
   output logic [((8 + 2*LENGTH_BITS + 2*COUNT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // from bit 0 up: event_res [2:0], element_kind [4:3], zero fill [7:5]
   output logic [7:0]  rsp_tuser
);

   localparam int DATA_BITS  = 8 + 2*LENGTH_BITS + 2*COUNT_BITS;
   localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
   localparam int HDR_BITS   = $clog2(MAX_HEADER_CHARS + 1);
   localparam logic [HDR_BITS-1:0] HDR_MAX = HDR_BITS'(MAX_HEADER_CHARS);

   // Parser phase: where in the line structure the next byte lands.
   typedef enum logic [2:0] {
      PH_START     = 3'd0,  // first byte of a header line
      PH_HEADER    = 3'd1,  // inside a header line
      PH_HEADER_LF = 3'd2,  // CR seen after a header, LF due
      PH_EMPTY_LF  = 3'd3,  // CR seen at line start, LF due
      PH_PAYLOAD   = 3'd4,  // bulk payload bytes
      PH_TRAIL1    = 3'd5,  // first trailer byte
      PH_TRAIL2    = 3'd6   // second trailer byte, element done
   } phase_type;

   // ---------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------
   phase_type             phase_ff,    phase_in;
   logic                  arr_ff,      arr_in;
   logic                  neg_ff,      neg_in;
   logic [HDR_BITS-1:0]   hdr_cnt_ff,  hdr_cnt_in;
   logic [LENGTH_BITS-1:0] value_ff,    value_in;
   logic [LENGTH_BITS-1:0] pay_left_ff, pay_left_in;
   logic [LENGTH_BITS-1:0] pend_ff,     pend_in;
   logic [COUNT_BITS-1:0]  elem_cnt_ff, elem_cnt_in;
   logic [COUNT_BITS-1:0]  top_cnt_ff,  top_cnt_in;
   logic                  err_ff,      err_in;

   // result register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [TDATA_BITS-1:0] rsp_tdata_ff,  rsp_tdata_in;
   logic [7:0]            rsp_tuser_ff,  rsp_tuser_in;

   logic req_xfer;

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   logic                   is_digit;
   logic [LENGTH_BITS-1:0] value_digit;

   ltfp_accum #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_accum (
      .value      (value_ff),
      .byte_in    (req_tdata),
      .is_digit   (is_digit),
      .value_next (value_digit)
   );

   // Element bookkeeping: a top-level element bumps the top counter, a child
   // consumes one pending slot; an array header then adds its children.
   logic [LENGTH_BITS-1:0] pend_dec;
   logic [LENGTH_BITS:0]   pend_sum;
   logic [LENGTH_BITS-1:0] pend_arr;
   logic [COUNT_BITS-1:0]  top_inc;
   logic [COUNT_BITS-1:0]  elem_inc;
   logic [LENGTH_BITS-1:0] pay_dec;
   logic                   sign_ok;

   assign pend_dec = (pend_ff == '0) ? pend_ff : pend_ff - 1'b1;
   assign pend_sum = {1'b0, pend_dec} + {1'b0, value_ff};
   assign pend_arr = pend_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : pend_sum[LENGTH_BITS-1:0];
   assign top_inc  = ((pend_ff == '0) && (top_cnt_ff != {COUNT_BITS{1'b1}})) ?
                     top_cnt_ff + 1'b1 : top_cnt_ff;
   assign elem_inc = (elem_cnt_ff != {COUNT_BITS{1'b1}}) ? elem_cnt_ff + 1'b1 : elem_cnt_ff;
   assign pay_dec  = (pay_left_ff != '0) ? pay_left_ff - 1'b1 : pay_left_ff;
   // a sign is allowed only at the first number position (after an optional '*')
   assign sign_ok  = (hdr_cnt_ff == {{(HDR_BITS-1){1'b0}}, arr_ff});

   // ---------------------------------------------------------------------
   // Next state and result for the byte on the input
   // ---------------------------------------------------------------------
   event_type              ev;
   kind_type               kind;
   logic [7:0]             pb;
   logic [LENGTH_BITS-1:0] len;
   logic [LENGTH_BITS-1:0] out_pend;
   logic [COUNT_BITS-1:0]  out_tot;
   logic [COUNT_BITS-1:0]  out_top;
   logic                   fail;
   logic                   cmd_done;
   logic                   elem_done;

   always_comb begin
      phase_in    = phase_ff;
      arr_in      = arr_ff;
      neg_in      = neg_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      value_in    = value_ff;
      pay_left_in = pay_left_ff;
      pend_in     = pend_ff;
      elem_cnt_in = elem_cnt_ff;
      top_cnt_in  = top_cnt_ff;
      err_in      = err_ff;
      ev          = EV_HEADER;
      kind        = KIND_EMPTY;
      pb          = 8'd0;
      len         = '0;
      fail        = 1'b0;
      cmd_done    = 1'b0;
      elem_done   = 1'b0;

      if (err_ff) begin
         fail = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_START, PH_HEADER: begin
               // line-start registers are already clear, so both phases share this path
               if (req_tdata == CHAR_CR) begin
                  phase_in = (phase_ff == PH_START) ? PH_EMPTY_LF : PH_HEADER_LF;
               end else begin
                  phase_in   = PH_HEADER;
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  priority if (hdr_cnt_ff >= HDR_MAX) begin
                     fail = 1'b1;
                  end else if (is_digit) begin
                     value_in = value_digit;
                  end else if ((req_tdata == CHAR_STAR) && (hdr_cnt_ff == '0)) begin
                     // an array may not open a command
                     if (elem_cnt_ff == '0) begin
                        fail = 1'b1;
                     end else begin
                        arr_in = 1'b1;
                     end
                  end else if (((req_tdata == CHAR_MINUS) || (req_tdata == CHAR_PLUS))
                               && sign_ok) begin
                     neg_in = (req_tdata == CHAR_MINUS);
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            PH_HEADER_LF: begin
               priority if (req_tdata != CHAR_LF) begin
                  fail = 1'b1;
               end else if (neg_ff && (value_ff != '0)) begin
                  elem_done = 1'b1;
                  kind      = KIND_NULL;
               end else if (value_ff == '0) begin
                  elem_done = 1'b1;
                  kind      = KIND_EMPTY;
               end else if (arr_ff) begin
                  elem_done = 1'b1;
                  kind      = KIND_ARRAY;
                  len       = value_ff;
               end else begin
                  pay_left_in = value_ff;
                  phase_in    = PH_PAYLOAD;
               end
            end
            PH_EMPTY_LF: begin
               if ((req_tdata != CHAR_LF) || (pend_ff != '0)) begin
                  fail = 1'b1;
               end else begin
                  cmd_done    = 1'b1;
                  ev          = EV_COMMAND;
                  phase_in    = PH_START;
                  arr_in      = 1'b0;
                  neg_in      = 1'b0;
                  hdr_cnt_in  = '0;
                  value_in    = '0;
                  pay_left_in = '0;
                  pend_in     = '0;
                  elem_cnt_in = '0;
                  top_cnt_in  = '0;
               end
            end
            PH_PAYLOAD: begin
               ev          = EV_PAYLOAD;
               pb          = req_tdata;
               pay_left_in = pay_dec;
               if (pay_dec == '0) begin
                  phase_in = PH_TRAIL1;
               end
            end
            PH_TRAIL1: begin
               phase_in = PH_TRAIL2;
            end
            default: begin
               // second trailer byte: the bulk element is complete
               elem_done = 1'b1;
               kind      = KIND_BULK;
               len       = value_ff;
            end
         endcase
      end

      if (elem_done) begin
         ev          = EV_ELEMENT;
         pend_in     = (kind == KIND_ARRAY) ? pend_arr : pend_dec;
         top_cnt_in  = top_inc;
         elem_cnt_in = elem_inc;
         phase_in    = PH_START;
         arr_in      = 1'b0;
         neg_in      = 1'b0;
         hdr_cnt_in  = '0;
         value_in    = '0;
      end

      // a failing byte leaves the state as it was and latches the error
      if (fail) begin
         phase_in    = phase_ff;
         arr_in      = arr_ff;
         neg_in      = neg_ff;
         hdr_cnt_in  = hdr_cnt_ff;
         value_in    = value_ff;
         pay_left_in = pay_left_ff;
         pend_in     = pend_ff;
         elem_cnt_in = elem_cnt_ff;
         top_cnt_in  = top_cnt_ff;
         err_in      = 1'b1;
         ev          = EV_ERROR;
         kind        = KIND_EMPTY;
         pb          = 8'd0;
         len         = '0;
      end

      // command done reports the finished command's counts, other events the new state
      out_pend = pend_in;
      out_tot  = cmd_done ? elem_cnt_ff : elem_cnt_in;
      out_top  = cmd_done ? top_cnt_ff  : top_cnt_in;
   end

   // ---------------------------------------------------------------------
   // Handshake: take a byte whenever the result register is empty or drains now
   // ---------------------------------------------------------------------
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (req_xfer) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      rsp_tdata_in = TDATA_BITS'({out_top, out_tot, out_pend, len, pb});
      rsp_tuser_in = {3'b000, kind, ev};
   end

   // parser state: advance only on an input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         arr_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         hdr_cnt_ff  <= '0;
         value_ff    <= '0;
         pay_left_ff <= '0;
         pend_ff     <= '0;
         elem_cnt_ff <= '0;
         top_cnt_ff  <= '0;
         err_ff      <= 1'b0;
      end else if (req_xfer) begin
         phase_ff    <= phase_in;
         arr_ff      <= arr_in;
         neg_ff      <= neg_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         value_ff    <= value_in;
         pay_left_ff <= pay_left_in;
         pend_ff     <= pend_in;
         elem_cnt_ff <= elem_cnt_in;
         top_cnt_ff  <= top_cnt_in;
         err_ff      <= err_in;
      end
   end

   // result register: valid is control, payload loads with each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[tb/sv/ltfp_result_checker.sv]
// Result checker for the length-prefixed text frame parser testbench.
// Predicts one result per accepted stream byte and compares result transfers in order.
// Depends on ltfp_pkg.
module ltfp_result_checker
   import ltfp_pkg::*;
#(
   parameter int LENGTH_BITS      = 31,
   parameter int COUNT_BITS       = 16,
   parameter int MAX_HEADER_CHARS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [((8 + 2*LENGTH_BITS + 2*COUNT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic [7:0]          rsp_tuser,
   output int                  failures,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_POS = 8;
   localparam int PEND_POS = LEN_POS + LENGTH_BITS;
   localparam int TOT_POS = PEND_POS + LENGTH_BITS;
   localparam int TOP_POS = TOT_POS + COUNT_BITS;
   localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;
   localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

   typedef enum logic [2:0] {
      LINE_START, IN_HEADER, HEADER_LF, EMPTY_LF, IN_PAYLOAD, TRAILER_1, TRAILER_2
   } line_phase_type;

   typedef struct packed {
      event_type               ev;
      kind_type                kind;
      logic [7:0]              data;
      logic [LENGTH_BITS-1:0]  length;
      logic [LENGTH_BITS-1:0]  pending;
      logic [COUNT_BITS-1:0]   total;
      logic [COUNT_BITS-1:0]   top;
   } parse_result_type;

   line_phase_type    line_phase;
   bit                array_header;
   bit                is_negative;
   bit                err_sticky;
   int                hdr_chars;
   longint unsigned   value_acc;
   longint unsigned   payload_left;
   longint unsigned   children;
   longint unsigned   elem_tally;
   longint unsigned   top_count;

   parse_result_type  predicted_results[$];
   int                mismatches = 0;

   assign failures = mismatches;

   function automatic parse_result_type make_result(input event_type ev,
                                                    input logic [7:0] data,
                                                    input kind_type kind,
                                                    input longint unsigned len,
                                                    input longint unsigned pend,
                                                    input longint unsigned tot,
                                                    input longint unsigned top);
      parse_result_type r;
      r.ev = ev;
      r.kind = kind;
      r.data = data;
      r.length = len[LENGTH_BITS-1:0];
      r.pending = pend[LENGTH_BITS-1:0];
      r.total = tot[COUNT_BITS-1:0];
      r.top = top[COUNT_BITS-1:0];
      return r;
   endfunction

   function automatic void clear_header();
      array_header = 1'b0;
      is_negative = 1'b0;
      hdr_chars = 0;
      value_acc = 0;
   endfunction

   function automatic void clear_parser();
      line_phase = LINE_START;
      clear_header();
      payload_left = 0;
      children = 0;
      elem_tally = 0;
      top_count = 0;
      err_sticky = 1'b0;
   endfunction

   function automatic parse_result_type raise_error();
      err_sticky = 1'b1;
      return make_result(EV_ERROR, 8'h00, KIND_EMPTY, 0, children, elem_tally, top_count);
   endfunction

   // A finished element either fills a pending array slot or is top level.
   function automatic void tally_element(input bit adds_children, input longint unsigned count);
      if (children == 0) begin
         if (top_count < CNT_MAX) top_count++;
      end else begin
         children--;
      end
      if (adds_children) begin
         if (count > LEN_MAX - children) children = LEN_MAX;
         else children += count;
      end
      if (elem_tally < CNT_MAX) elem_tally++;
   endfunction

   function automatic parse_result_type finish_element(input kind_type kind,
                                                       input longint unsigned len);
      tally_element(kind == KIND_ARRAY, len);
      clear_header();
      line_phase = LINE_START;
      return make_result(EV_ELEMENT, 8'h00, kind, len, children, elem_tally, top_count);
   endfunction

   function automatic parse_result_type parse_byte(input logic [7:0] b);
      longint unsigned digit;
      longint unsigned saved_tot;
      longint unsigned saved_top;
      int numpos;
      if (err_sticky) return raise_error();
      if (line_phase == LINE_START) begin
         if (b == CHAR_CR) begin
            line_phase = EMPTY_LF;
            return make_result(EV_HEADER, 8'h00, KIND_EMPTY, 0, children, elem_tally,
                               top_count);
         end
         line_phase = IN_HEADER;
      end
      case (line_phase)
         IN_HEADER: begin
            numpos = hdr_chars - (array_header ? 1 : 0);
            if (b == CHAR_CR) begin
               line_phase = HEADER_LF;
            end else if (hdr_chars >= MAX_HEADER_CHARS) begin
               return raise_error();
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               digit = longint'(b - CHAR_ZERO);
               if (value_acc > (LEN_MAX - digit) / 10) value_acc = LEN_MAX;
               else value_acc = value_acc * 10 + digit;
               hdr_chars++;
            end else if (b == CHAR_STAR && hdr_chars == 0) begin
               // an array may not open a command
               if (elem_tally == 0) return raise_error();
               array_header = 1'b1;
               hdr_chars++;
            end else if ((b == CHAR_MINUS || b == CHAR_PLUS) && numpos == 0) begin
               is_negative = (b == CHAR_MINUS);
               hdr_chars++;
            end else begin
               return raise_error();
            end
         end
         HEADER_LF: begin
            if (b != CHAR_LF) return raise_error();
            if (is_negative && value_acc != 0) return finish_element(KIND_NULL, 0);
            if (value_acc == 0) return finish_element(KIND_EMPTY, 0);
            if (array_header) return finish_element(KIND_ARRAY, value_acc);
            payload_left = value_acc;
            line_phase = IN_PAYLOAD;
         end
         EMPTY_LF: begin
            saved_tot = elem_tally;
            saved_top = top_count;
            if (b != CHAR_LF || children != 0) return raise_error();
            clear_parser();
            return make_result(EV_COMMAND, 8'h00, KIND_EMPTY, 0, 0, saved_tot, saved_top);
         end
         IN_PAYLOAD: begin
            if (payload_left > 0) payload_left--;
            if (payload_left == 0) line_phase = TRAILER_1;
            return make_result(EV_PAYLOAD, b, KIND_EMPTY, 0, children, elem_tally, top_count);
         end
         TRAILER_1: line_phase = TRAILER_2;
         default: return finish_element(KIND_BULK, value_acc);
      endcase
      return make_result(EV_HEADER, 8'h00, KIND_EMPTY, 0, children, elem_tally, top_count);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      parse_result_type want;
      if (reset) begin
         clear_parser();
         predicted_results.delete();
      end else begin
         if (req_tvalid && req_tready) predicted_results.push_back(parse_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $error("result transfer with no stream byte waiting for it");
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               check_field("event_res", want.ev, rsp_tuser[2:0]);
               check_field("element_kind", want.kind, rsp_tuser[4:3]);
               check_field("payload_byte", want.data, rsp_tdata[7:0]);
               check_field("element_length", want.length, rsp_tdata[LEN_POS +: LENGTH_BITS]);
               check_field("children_pending", want.pending,
                           rsp_tdata[PEND_POS +: LENGTH_BITS]);
               check_field("total_elements", want.total, rsp_tdata[TOT_POS +: COUNT_BITS]);
               check_field("top_level_elements", want.top, rsp_tdata[TOP_POS +: COUNT_BITS]);
            end
         end
      end
      outstanding <= predicted_results.size();
   end

endmodule

[tb/sv/length_prefixed_text_frame_parser_tb.sv]
// Top of the length-prefixed text frame parser testbench: clock, reset, byte stimulus,
// result-side stalls and the verdict. Depends on ltfp_pkg, the parser RTL and
// ltfp_result_checker.
module length_prefixed_text_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ltfp_pkg::*;

   localparam int LENGTH_BITS = 31;
   localparam int COUNT_BITS = 16;
   localparam int MAX_HEADER_CHARS = 31;
   localparam int RSP_W = ((8 + 2*LENGTH_BITS + 2*COUNT_BITS + 7) / 8) * 8;
   // stream length before the closing error sequence
   localparam int STREAM_TARGET = 1080;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // [7:0] data_in
   logic              rsp_tvalid;
   logic              rsp_tready;
   // payload_byte, element_length, children_pending, total_elements,
   // top_level_elements, zero fill
   logic [RSP_W-1:0]  rsp_tdata;
   // event_res [2:0], element_kind [4:3], zero fill [7:5]
   logic [7:0]        rsp_tuser;

   int                chk_failures;
   int                chk_outstanding;

   // Idling phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both, 4 none again.
   int                idle_mode = 0;
   bit                hold_now = 1'b0;

   logic [7:0]        stream_q[$];
   int                gen_pending;
   int                gen_elements;

   length_prefixed_text_frame_parser #(
      .LENGTH_BITS      (LENGTH_BITS),
      .COUNT_BITS       (COUNT_BITS),
      .MAX_HEADER_CHARS (MAX_HEADER_CHARS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ltfp_result_checker #(
      .LENGTH_BITS      (LENGTH_BITS),
      .COUNT_BITS       (COUNT_BITS),
      .MAX_HEADER_CHARS (MAX_HEADER_CHARS)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .failures    (chk_failures),
      .outstanding (chk_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append a header line (or an empty line for "") with its CR LF.
   task automatic put_line(input string s);
      for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
      stream_q.push_back(CHAR_CR);
      stream_q.push_back(CHAR_LF);
   endtask

   // Append one well-formed element. While filling, no new array children are opened,
   // so the pending count only drains.
   task automatic put_element(input bit filling);
      int pick;
      int n;
      int zeros;
      bit star_ok;
      bit array_ok;
      bit long_head;
      string head;
      string sign;
      star_ok = (gen_elements > 0);
      array_ok = star_ok && !filling && gen_pending <= 6;
      if (gen_pending > 0) gen_pending--;
      gen_elements++;
      pick = $urandom_range(99);
      sign = "";
      if (pick >= 82 && array_ok) begin
         // array header: its children come as the following elements
         n = $urandom_range(1, 3);
         if ($urandom_range(3) == 0) sign = "+";
         put_line($sformatf("*%s%0d", sign, n));
         gen_pending += n;
      end else if (pick >= 72) begin
         // null: a negative value, now and then far past saturation
         if ($urandom_range(7) == 0) head = "-99999999999999999999";
         else head = $sformatf("-%0d", $urandom_range(1, 99));
         if (star_ok && $urandom_range(1) == 1) head = {"*", head};
         put_line(head);
      end else if (pick >= 60) begin
         // empty: a zero value, or a sign or star with no digits
         case ($urandom_range(star_ok ? 8 : 5))
            0: head = "0";
            1: head = "+0";
            2: head = "-0";
            3: head = "-";
            4: head = "+";
            5: head = "000";
            6: head = "*";
            7: head = "*0";
            default: head = "*-";
         endcase
         put_line(head);
      end else begin
         // bulk: mostly short payloads, a few longer ones
         n = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         head = $sformatf("%0d", n);
         long_head = ($urandom_range(15) == 0);
         // a long header fills exactly the allowed header width
         zeros = long_head ? MAX_HEADER_CHARS - 1 - head.len()
                           : (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
         repeat (zeros) head = {"0", head};
         if (long_head || $urandom_range(3) == 0) head = {"+", head};
         put_line(head);
         repeat (n) stream_q.push_back(8'($urandom_range(255)));
         // trailer bytes are not checked by the parser
         repeat (2) stream_q.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic put_command();
      int count;
      count = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
      gen_pending = 0;
      gen_elements = 0;
      repeat (count) put_element(1'b0);
      while (gen_pending > 0) put_element(1'b1);
      put_line("");
   endtask

   // Receiver: random stalls by phase, plus one long hold-off counted here.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 1'b0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_mode == 2) begin
            rsp_tready <= ($urandom_range(99) >= 66);
         end else if (idle_mode == 3) begin
            rsp_tready <= ($urandom_range(99) >= 20);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int total_bytes;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;

      // Directed command: a bulk element whose payload holds 00, FF and a CR, then an
      // array of two children (one null, one empty), then the empty line.
      put_line("3");
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      stream_q.push_back(CHAR_CR);
      stream_q.push_back(CHAR_LF);
      stream_q.push_back(8'h80);
      put_line("*2");
      put_line("-7");
      put_line("+0");
      put_line("");

      // Random well-formed commands make up the bulk of the stream.
      while (stream_q.size() < STREAM_TARGET) put_command();

      // Errors are sticky until reset, so one broken sequence closes the stream,
      // followed by noise that must keep answering with errors.
      case ($urandom_range(7))
         0: put_line("*2");        // array header opening a command
         1: put_line("12x");       // stray character in a header
         2: put_line("1-5");       // sign after the first number position
         3: begin                  // CR in a header not followed by LF
            stream_q.push_back(CHAR_ZERO + 8'd5);
            stream_q.push_back(CHAR_CR);
            stream_q.push_back(CHAR_STAR);
         end
         4: begin                  // CR at line start not followed by LF
            stream_q.push_back(CHAR_CR);
            stream_q.push_back(CHAR_PLUS);
         end
         5: repeat (MAX_HEADER_CHARS + 1) stream_q.push_back(CHAR_ZERO);
         6: begin                  // saturated array count still pending at the end
            put_line("1");
            repeat (3) stream_q.push_back(8'($urandom_range(255)));
            put_line("*99999999999");
            put_line("");
         end
         default: put_line("1*");  // star past line start
      endcase
      repeat (8) stream_q.push_back(8'($urandom_range(255)));
      total_bytes = stream_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int idx = 0; idx < total_bytes; idx++) begin
         idle_mode = idx * 5 / total_bytes;
         // long receiver hold-off while the sender keeps offering bytes
         if (idx == total_bytes / 10) hold_now = 1'b1;
         // drain: hold the stream until every predicted result has arrived
         if (idx == total_bytes * 3 / 5) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (chk_outstanding != 0) @(posedge clock);
         end
         if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < ((idle_mode == 1) ? 66 : 20)) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata <= stream_q[idx];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      // Wait for the tail of the results and for any stray transfers.
      @(posedge clock);
      while (chk_outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (chk_failures == 0 && chk_outstanding == 0) begin
         $display("PASS length_prefixed_text_frame_parser");
      end else begin
         $display("FAIL length_prefixed_text_frame_parser");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin : watchdog
      #3000000;
      $display("FAIL length_prefixed_text_frame_parser");
      $finish;
   end

endmodule
